FILE: hw/rtl/assert_macros.svh
// Assertion macros shared by the checker modules.
// Each macro expects clk and rst_n to be visible where it is used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked only while out of reset.
`define ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked on every edge, reset included.
`define ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: hw/rtl/lru_age_pkg.sv
// Types and codes for the LRU age replacement block.
// No dependencies; used by the top level and the checker.
package lru_age_pkg;

  typedef enum logic {
    REQ_TOUCH  = 1'b0,
    REQ_VICTIM = 1'b1
  } req_t;

  typedef enum logic {
    ST_CLEAR,
    ST_RUN
  } state_t;

  // Control of the item held in the update stage.
  typedef struct packed {
    logic valid;
    logic victim;
    logic upd;
    logic set_ok;
  } ctl_t;

endpackage

FILE: hw/rtl/lru_age_mem.sv
// Age row memory: one write port, one read port, registered read data.
// Depends on nothing but its parameters.
module lru_age_mem #(
  parameter int SETS  = 64,
  parameter int ROW_W = 24,
  parameter int SW    = 6
) (
  input  logic             clk,
  input  logic             rd_en,
  input  logic [SW-1:0]    rd_addr,
  output logic [ROW_W-1:0] rd_data,
  input  logic             wr_en,
  input  logic [SW-1:0]    wr_addr,
  input  logic [ROW_W-1:0] wr_data
);

  logic [ROW_W-1:0] mem [SETS];
  logic [ROW_W-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

FILE: hw/rtl/lru_age_calc.sv
// Row update and oldest-way search for one age row.
// Depends on nothing but its parameters.
module lru_age_calc #(
  parameter int WAYS = 8,
  parameter int WW   = 3
) (
  input  logic [WAYS*WW-1:0] row,
  input  logic [WW-1:0]      way,
  output logic [WAYS*WW-1:0] row_nxt,
  output logic [WW-1:0]      victim
);

  localparam int P = 2 ** WW;

  logic [WW-1:0] limit;
  logic [WW-1:0] age;
  logic [WW-1:0] ta [WW+1][P];
  logic [WW-1:0] ti [WW+1][P];

  // Touch: younger ways age by one, the touched way becomes youngest.
  always_comb begin
    limit   = row[way*WW +: WW];
    row_nxt = row;
    age     = '0;
    for (int i = 0; i < WAYS; i++) begin
      age = row[i*WW +: WW];
      if (WW'(i) == way) begin
        row_nxt[i*WW +: WW] = '0;
      end else if (age < limit) begin
        row_nxt[i*WW +: WW] = WW'(age + 1'b1);
      end
    end
  end

  // Pairwise max tree; left side keeps ties, so the lowest way wins.
  always_comb begin
    for (int l = 0; l <= WW; l++) begin
      for (int i = 0; i < P; i++) begin
        ta[l][i] = '0;
        ti[l][i] = '0;
      end
    end
    for (int i = 0; i < P; i++) begin
      ti[0][i] = WW'(i);
      if (i < WAYS) begin
        ta[0][i] = row[i*WW +: WW];
      end
    end
    for (int l = 0; l < WW; l++) begin
      for (int i = 0; i < (P >> (l + 1)); i++) begin
        if (ta[l][2*i+1] > ta[l][2*i]) begin
          ta[l+1][i] = ta[l][2*i+1];
          ti[l+1][i] = ti[l][2*i+1];
        end else begin
          ta[l+1][i] = ta[l][2*i];
          ti[l+1][i] = ti[l][2*i];
        end
      end
    end
    victim = ti[WW][0];
  end

endmodule

FILE: hw/rtl/lru_age_replacement_core.sv
// LRU replacement state for a set-associative cache, one age per way.
// Input channel (in_valid/in_ready): a touch (in_req_type = 0) moves a way
// of a set to age zero and ages the younger ways; a write-back hit, a set
// at or beyond SETS or a way at or beyond WAYS changes nothing. A victim
// request (in_req_type = 1) yields one item on the output channel
// (out_valid/out_ready): the oldest way, lowest index on ties, or 0 for a
// set out of range. Touches yield nothing.
// A victim request accepted on the input enters the update stage; its result
// is then registered in the output register, which drives out_valid.
// Throughput: one item per cycle while nothing stalls; the age memory is
// read at acceptance and written back from the update stage, with the last
// written row forwarded to the following item.
// Reset: a clearing pass writes every row to all ages WAYS-1, one row per
// cycle, from row 0 up to row SETS-1; in_ready stays low until it ends.
// Stall: a victim result waits in the output register; with that register
// full and out_ready low, a victim in the update stage holds and in_ready
// drops. Touches keep flowing while the output waits.
// Depends on lru_age_pkg, lru_age_mem and lru_age_calc.
module lru_age_replacement_core
  import lru_age_pkg::*;
#(
  parameter int SETS = 64,
  parameter int WAYS = 8
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic       in_req_type,
  input  logic [5:0] in_set_index,
  input  logic [2:0] in_way,
  input  logic       in_hit,
  input  logic       in_is_writeback,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [2:0] out_victim_way
);

  localparam int SW = (SETS > 1) ? $clog2(SETS) : 1;
  localparam int WW = $clog2(WAYS);
  localparam int RW = WAYS * WW;
  localparam int IW = (SW > 6) ? SW : 6;
  localparam int XW = (WW > 3) ? WW : 3;
  localparam logic [RW-1:0] RST_ROW = {WAYS{WW'(WAYS - 1)}};

  state_t        state_r, state_nxt;
  logic [SW-1:0] clr_cnt_r, clr_cnt_nxt;
  logic          clearing;

  ctl_t          ctl_r;
  logic [SW-1:0] s1_set_r;
  logic [WW-1:0] s1_way_r;

  logic          fwd_valid_r;
  logic [SW-1:0] fwd_set_r;
  logic [RW-1:0] fwd_row_r;

  logic          out_valid_r;
  logic [2:0]    out_victim_r;

  logic          accept;
  logic [IW-1:0] set_ext;
  logic [XW-1:0] way_ext;
  logic          set_ok;
  logic          way_ok;
  ctl_t          ctl_in;
  logic          s1_adv;
  logic          s1_wr;
  logic [RW-1:0] rd_row;
  logic [RW-1:0] cur_row;
  logic [RW-1:0] new_row;
  logic [WW-1:0] victim;
  logic [XW-1:0] victim_ext;
  logic          mem_we;
  logic [SW-1:0] mem_waddr;
  logic [RW-1:0] mem_wdata;

  // Clearing pass sequencer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_CLEAR;
      clr_cnt_r <= '0;
    end else begin
      state_r   <= state_nxt;
      clr_cnt_r <= clr_cnt_nxt;
    end
  end

  always_comb begin
    state_nxt   = state_r;
    clr_cnt_nxt = clr_cnt_r;
    clearing    = 1'b0;
    case (state_r)
      ST_CLEAR: begin
        clearing    = 1'b1;
        clr_cnt_nxt = SW'(clr_cnt_r + 1'b1);
        if (clr_cnt_r == SW'(SETS - 1)) begin
          state_nxt   = ST_RUN;
          clr_cnt_nxt = '0;
        end
      end
      ST_RUN: begin
        clearing = 1'b0;
      end
      default: begin
        state_nxt = ST_CLEAR;
      end
    endcase
  end

  // Request decode
  assign accept  = in_valid && in_ready;
  assign set_ext = IW'(in_set_index);
  assign way_ext = XW'(in_way);
  assign set_ok  = 32'(in_set_index) < SETS;
  assign way_ok  = 32'(in_way) < WAYS;

  always_comb begin
    ctl_in        = '0;
    ctl_in.valid  = in_valid;
    ctl_in.victim = (in_req_type == REQ_VICTIM);
    ctl_in.set_ok = set_ok;
    ctl_in.upd    = (in_req_type == REQ_TOUCH) && !(in_hit && in_is_writeback)
                    && set_ok && way_ok;
  end

  assign s1_adv   = !ctl_r.victim || !out_valid_r || out_ready;
  assign in_ready = !clearing && (!ctl_r.valid || s1_adv);
  assign s1_wr    = ctl_r.valid && ctl_r.upd;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl_r <= '0;
    end else if (in_ready) begin
      ctl_r <= ctl_in;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready) begin
      s1_set_r <= set_ext[SW-1:0];
      s1_way_r <= way_ext[WW-1:0];
    end
  end

  // Age memory
  assign mem_we    = clearing || s1_wr;
  assign mem_waddr = clearing ? clr_cnt_r : s1_set_r;
  assign mem_wdata = clearing ? RST_ROW : new_row;

  lru_age_mem #(
    .SETS  (SETS),
    .ROW_W (RW),
    .SW    (SW)
  ) u_mem (
    .clk     (clk),
    .rd_en   (accept),
    .rd_addr (set_ext[SW-1:0]),
    .rd_data (rd_row),
    .wr_en   (mem_we),
    .wr_addr (mem_waddr),
    .wr_data (mem_wdata)
  );

  // The write of the item ahead lands in memory after this item's read.
  assign cur_row = (fwd_valid_r && fwd_set_r == s1_set_r) ? fwd_row_r : rd_row;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fwd_valid_r <= 1'b0;
    end else if (clearing) begin
      fwd_valid_r <= 1'b0;
    end else if (s1_wr) begin
      fwd_valid_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_wr) begin
      fwd_set_r <= s1_set_r;
      fwd_row_r <= new_row;
    end
  end

  lru_age_calc #(
    .WAYS (WAYS),
    .WW   (WW)
  ) u_calc (
    .row     (cur_row),
    .way     (s1_way_r),
    .row_nxt (new_row),
    .victim  (victim)
  );

  // Output register
  assign victim_ext = XW'(victim);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (ctl_r.valid && ctl_r.victim && s1_adv) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl_r.valid && ctl_r.victim && s1_adv) begin
      out_victim_r <= ctl_r.set_ok ? victim_ext[2:0] : 3'd0;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_victim_way = out_victim_r;

endmodule

FILE: hw/rtl/lru_age_chk.sv
// Port-level checker for lru_age_replacement_core, bound to the top level.
// Depends on lru_age_pkg and assert_macros.svh.
`include "assert_macros.svh"

module lru_age_chk
  import lru_age_pkg::*;
#(
  parameter int WAYS = 8
) (
  input logic       clk,
  input logic       rst_n,
  input logic       in_valid,
  input logic       in_ready,
  input logic       in_req_type,
  input logic       out_valid,
  input logic       out_ready,
  input logic [2:0] out_victim_way
);

  // No item is taken in the cycle after reset: the clearing pass runs first.
  `ASSERT_ALWAYS(a_clear_after_reset, !rst_n |=> !in_ready, "in_ready high after reset")

  `ASSERT_CLK(a_out_hold, out_valid && !out_ready |=> out_valid && $stable(out_victim_way), "output item changed while stalled")

  // A fresh result comes from an accepted victim item that has passed through the update stage.
  `ASSERT_CLK(a_out_source, $rose(out_valid) |-> $past(in_valid && in_ready && in_req_type == REQ_VICTIM, 2), "result without victim request")

  `ASSERT_CLK(a_victim_range, out_valid |-> (WAYS > 8 || 32'(out_victim_way) < WAYS), "victim way out of range")

endmodule

bind lru_age_replacement_core lru_age_chk #(
  .WAYS (WAYS)
) u_lru_age_chk (
  .clk            (clk),
  .rst_n          (rst_n),
  .in_valid       (in_valid),
  .in_ready       (in_ready),
  .in_req_type    (in_req_type),
  .out_valid      (out_valid),
  .out_ready      (out_ready),
  .out_victim_way (out_victim_way)
);
